// File: rtl/block_cache_tag_controller_core_defines.svh
// Assertion macros used by the checker file of the tag controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BLOCK_CACHE_TAG_CONTROLLER_CORE_DEFINES_SVH
`define BLOCK_CACHE_TAG_CONTROLLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tag controller assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tag controller assertion failed");

`endif

// File: rtl/bctc_pkg.sv
package bctc_pkg;

  localparam int ACT_W     = 2;
  localparam int DEV_W     = 8;
  localparam int BLK_W     = 32;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 6;
  localparam int CMD_DEV_W = 3;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd4;

  // One tag entry: device and block number of the cached block.
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } tag_t;

  // Outcome of comparing one slot against the pending request.
  typedef struct packed {
    logic hit;    // slot is valid and holds the requested block
    logic avail;  // slot is free or clean, so it may be replaced
  } match_t;

endpackage

// File: rtl/bctc_tag_ram.sv
module bctc_tag_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  bctc_pkg::tag_t           wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output bctc_pkg::tag_t           rdata_o
);
  import bctc_pkg::*;

  tag_t mem [DEPTH];
  tag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bctc_match.sv
module bctc_match (
  input  logic             valid_i,
  input  logic             dirty_i,
  input  bctc_pkg::tag_t   stored_i,
  input  bctc_pkg::tag_t   req_i,
  output bctc_pkg::match_t match_o
);
  import bctc_pkg::*;

  // A slot that is not valid never hits, whatever its tag storage holds.
  assign match_o.hit   = valid_i && (stored_i == req_i);
  assign match_o.avail = !valid_i || !dirty_i;

endmodule

// File: rtl/block_cache_tag_controller_core.sv
// Fully associative write-back tag controller.
// A request is a transaction taken when start_i is high and busy_o is low; it
// carries an action (read or write), a device and a block number. Results leave
// on strobe_o, one per cycle, each valid for exactly that one cycle; last_o marks
// the reply that closes a request. The receiver cannot stall the block.
// An invalid action or a device of DEVICES or more gives a single error result
// in the next cycle, with busy_o staying low, so a new request may follow at once.
// A valid request walks the tag RAM one slot per cycle through a single compare
// unit. The tag RAM read is registered, so each slot is compared in the cycle
// after it is read; a hit goes to ST_REPLY, which registers the reply. A miss
// walks all ENTRIES slots and then issues an optional writeback command, a load
// command and the reply, one per cycle; the next request can be taken in the
// cycle in which the reply is shown.
// busy_o is high from the cycle after acceptance until the reply is shown.
// Reset clears all valid and dirty marks at once; the tag RAM itself is not
// cleared, as its contents are only looked at for valid slots.
module block_cache_tag_controller_core #(
  parameter int ENTRIES = 64,
  parameter int DEVICES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [bctc_pkg::ACT_W-1:0]        action_i,
  input  logic [bctc_pkg::DEV_W-1:0]        device_i,
  input  logic [bctc_pkg::BLK_W-1:0]        block_number_i,
  output logic                              strobe_o,
  output logic [bctc_pkg::KIND_W-1:0]       kind_o,
  output logic [bctc_pkg::SLOT_W-1:0]       slot_o,
  output logic [bctc_pkg::CMD_DEV_W-1:0]    cmd_device_o,
  output logic [bctc_pkg::BLK_W-1:0]        cmd_block_o,
  output logic                              last_o
);
  import bctc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
  localparam logic [DEV_W:0]   DEV_LIM  = (DEV_W + 1)'(DEVICES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_WB    = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_REPLY = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]   victim_q, victim_d;
  logic               found_q, found_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;

  // Request and writeback payload; no reset needed.
  logic               is_write_q, is_write_d;
  tag_t               req_q, req_d;
  tag_t               wb_tag_q, wb_tag_d;

  // Result registers.
  logic                 strobe_q, strobe_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [CMD_DEV_W-1:0] cmd_dev_q, cmd_dev_d;
  logic [BLK_W-1:0]     cmd_blk_q, cmd_blk_d;
  logic                 last_q, last_d;

  logic   rd_en;
  logic   wr_en;
  logic   req_bad;
  tag_t   rd_tag;
  match_t match;

  assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_END);
  assign wr_en   = (state_q == ST_LOAD);
  assign req_bad = (action_i != ACT_READ && action_i != ACT_WRITE) ||
                   ({1'b0, device_i} >= DEV_LIM);

  bctc_tag_ram #(
    .DEPTH(ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (victim_q),
    .wdata_i (req_q),
    .re_i    (rd_en),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_tag)
  );

  // The one compare unit, fed with the slot read in the previous cycle.
  bctc_match u_match (
    .valid_i  (valid_q[cmp_idx_q]),
    .dirty_i  (dirty_q[cmp_idx_q]),
    .stored_i (rd_tag),
    .req_i    (req_q),
    .match_o  (match)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = rd_en;
    cmp_idx_d  = cnt_q[IDX_W-1:0];
    victim_d   = victim_q;
    found_d    = found_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    is_write_d = is_write_q;
    req_d      = req_q;
    wb_tag_d   = wb_tag_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    slot_d     = slot_q;
    cmd_dev_d  = cmd_dev_q;
    cmd_blk_d  = cmd_blk_q;
    last_d     = last_q;

    if (rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_bad) begin
            // Rejected requests answer at once and leave the state untouched.
            strobe_d  = 1'b1;
            kind_d    = KIND_ERROR;
            slot_d    = '0;
            cmd_dev_d = '0;
            cmd_blk_d = '0;
            last_d    = 1'b1;
          end else begin
            is_write_d = (action_i == ACT_WRITE);
            req_d.dev  = device_i;
            req_d.blk  = block_number_i;
            cnt_d      = '0;
            found_d    = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q) begin
          if (match.hit) begin
            victim_d = cmp_idx_q;
            state_d  = ST_REPLY;
          end else begin
            // Remember the lowest slot that may be replaced.
            if (match.avail && !found_q) begin
              found_d  = 1'b1;
              victim_d = cmp_idx_q;
            end
            if (cmp_idx_q == LAST_IDX) begin
              // The last slot is the victim when all slots are dirty, so its
              // tags are kept for the writeback command.
              wb_tag_d = rd_tag;
              if (found_q || match.avail) begin
                state_d = ST_LOAD;
              end else begin
                victim_d = LAST_IDX;
                state_d  = ST_WB;
              end
            end
          end
        end
      end
      ST_WB: begin
        strobe_d          = 1'b1;
        kind_d            = KIND_WRITEBACK;
        slot_d            = SLOT_W'(victim_q);
        cmd_dev_d         = wb_tag_q.dev[CMD_DEV_W-1:0];
        cmd_blk_d         = wb_tag_q.blk;
        last_d            = 1'b0;
        dirty_d[victim_q] = 1'b0;
        state_d           = ST_LOAD;
      end
      ST_LOAD: begin
        strobe_d          = 1'b1;
        kind_d            = KIND_LOAD;
        slot_d            = SLOT_W'(victim_q);
        cmd_dev_d         = req_q.dev[CMD_DEV_W-1:0];
        cmd_blk_d         = req_q.blk;
        last_d            = 1'b0;
        valid_d[victim_q] = 1'b1;
        dirty_d[victim_q] = 1'b0;
        state_d           = ST_REPLY;
      end
      ST_REPLY: begin
        strobe_d  = 1'b1;
        kind_d    = is_write_q ? KIND_WRITE : KIND_READ;
        slot_d    = SLOT_W'(victim_q);
        cmd_dev_d = req_q.dev[CMD_DEV_W-1:0];
        cmd_blk_d = req_q.blk;
        last_d    = 1'b1;
        if (is_write_q) begin
          dirty_d[victim_q] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      victim_q  <= '0;
      found_q   <= 1'b0;
      valid_q   <= '0;
      dirty_q   <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      victim_q  <= victim_d;
      found_q   <= found_d;
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_write_q <= is_write_d;
    req_q      <= req_d;
    wb_tag_q   <= wb_tag_d;
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    cmd_dev_q  <= cmd_dev_d;
    cmd_blk_q  <= cmd_blk_d;
    last_q     <= last_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign strobe_o     = strobe_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign cmd_device_o = cmd_dev_q;
  assign cmd_block_o  = cmd_blk_q;
  assign last_o       = last_q;

endmodule

// File: rtl/bctc_checker.sv
`include "block_cache_tag_controller_core_defines.svh"

module bctc_checker #(
  parameter int DEVICES = 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [bctc_pkg::ACT_W-1:0]     action_i,
  input logic [bctc_pkg::DEV_W-1:0]     device_i,
  input logic                           strobe_o,
  input logic [bctc_pkg::KIND_W-1:0]    kind_o,
  input logic [bctc_pkg::SLOT_W-1:0]    slot_o,
  input logic [bctc_pkg::CMD_DEV_W-1:0] cmd_device_o,
  input logic [bctc_pkg::BLK_W-1:0]     cmd_block_o,
  input logic                           last_o
);
  import bctc_pkg::*;

  localparam logic [DEV_W:0] DEV_LIM = (DEV_W + 1)'(DEVICES);

  logic bad_take;
  logic err_shown;
  logic err_ok;
  logic wb_shown;
  logic load_shown;
  logic reply_shown;

  assign bad_take    = start_i && !busy_o &&
                       ((action_i != ACT_READ && action_i != ACT_WRITE) ||
                        ({1'b0, device_i} >= DEV_LIM));
  assign err_shown   = strobe_o && kind_o == KIND_ERROR;
  assign err_ok      = err_shown && last_o && !busy_o;
  assign wb_shown    = strobe_o && kind_o == KIND_WRITEBACK;
  assign load_shown  = strobe_o && kind_o == KIND_LOAD;
  assign reply_shown = strobe_o && last_o && (kind_o == KIND_READ || kind_o == KIND_WRITE);

  // A rejected request answers with one error reply next cycle and stays idle.
  `BCTC_ASSERT_NEXT(a_reject, bad_take, err_ok)
  // Error replies carry zero payload.
  `BCTC_ASSERT_SAME(a_err_zero, err_shown, slot_o == '0 && cmd_device_o == '0 && cmd_block_o == '0)
  // A writeback command is always followed by the load into the same slot.
  `BCTC_ASSERT_NEXT(a_wb_load, wb_shown, load_shown && $stable(slot_o))
  // A load command is followed by the closing reply for the same block.
  `BCTC_ASSERT_NEXT(a_load_reply, load_shown, reply_shown && $stable(cmd_block_o))
  // The block drops busy only while showing the closing reply.
  `BCTC_ASSERT_SAME(a_busy_fall, $fell(busy_o), strobe_o && last_o)

endmodule

bind block_cache_tag_controller_core bctc_checker #(
  .DEVICES(DEVICES)
) u_bctc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .action_i     (action_i),
  .device_i     (device_i),
  .strobe_o     (strobe_o),
  .kind_o       (kind_o),
  .slot_o       (slot_o),
  .cmd_device_o (cmd_device_o),
  .cmd_block_o  (cmd_block_o),
  .last_o       (last_o)
);
